// ===== design/pprd_pkg.sv =====
// Package for the pinhole projection block: payload widths, configuration codes,
// status codes, shared structures and saturation helpers. No dependencies.
package pprd_pkg;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int CAM_W       = 51;

	localparam logic [CFG_INDEX_W-1:0] CFG_ROT0  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROT1  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROT2  = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_TXY   = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_TZ    = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_FOCAL = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_PP    = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SKD   = 4'd7;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_DEPTH_ZERO = 2'd1;
	localparam logic [1:0] ST_SATURATED  = 2'd2;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [47:0] rot0;
		logic [47:0] rot1;
		logic [47:0] rot2;
		logic [63:0] txy;
		logic [31:0] tz;
		logic [63:0] focal;
		logic [63:0] pp;
		logic [63:0] skd;
	} cfg_t;

	typedef struct packed {
		logic signed [CAM_W-1:0] xc;
		logic signed [CAM_W-1:0] yc;
		logic signed [CAM_W-1:0] zc;
	} cam_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} clamp_t;

	function automatic clamp_t clamp32(input logic signed [63:0] v, input logic sym);
		clamp_t r;
		logic signed [63:0] lo;
		lo = sym ? -S32_MAX : S32_MIN;
		r.sat = 1'b0;
		r.val = v[31:0];
		if (v > S32_MAX) begin
			r.sat = 1'b1;
			r.val = S32_MAX[31:0];
		end else if (v < lo) begin
			r.sat = 1'b1;
			r.val = lo[31:0];
		end
		return r;
	endfunction

endpackage

// ===== design/pprd_if.sv =====
// Channel interfaces of the pinhole projection block: world points, pixels and
// configuration writes. Depends on pprd_pkg.
interface pprd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] world_x;
	logic signed [31:0] world_y;
	logic signed [31:0] world_z;
	modport source (output valid, world_x, world_y, world_z, input ready);
	modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

interface pprd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] image_u;
	logic signed [31:0] image_v;
	logic [1:0]         status;
	modport source (output valid, image_u, image_v, status, input ready);
	modport sink (input valid, image_u, image_v, status, output ready);
endinterface

interface pprd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pprd_pkg::CFG_INDEX_W-1:0] index;
	logic [pprd_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pprd_front.sv =====
// Front end: accepts world points and moves them into the camera frame in two stages.
// Depends on pprd_pkg and pprd_if.
module pprd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  pprd_pkg::cfg_t      cfg,
	pprd_in_if.sink             point,
	input  logic                full,
	output logic                push,
	output pprd_pkg::cam_t      item
);

	localparam int CAM_W = pprd_pkg::CAM_W;

	logic               en;
	logic               v_s1, v_s2;
	logic signed [47:0] p_s1 [0:2][0:2];
	pprd_pkg::cam_t     cam_s2;
	logic [47:0]        rows [0:2];
	logic signed [31:0] w [0:2];
	logic signed [31:0] t [0:2];

	assign en   = !(v_s2 && full);
	assign push = v_s2 && !full;
	assign item = cam_s2;
	assign point.ready = en;

	assign rows[0] = cfg.rot0;
	assign rows[1] = cfg.rot1;
	assign rows[2] = cfg.rot2;
	assign w[0] = point.world_x;
	assign w[1] = point.world_y;
	assign w[2] = point.world_z;
	assign t[0] = cfg.txy[31:0];
	assign t[1] = cfg.txy[63:32];
	assign t[2] = cfg.tz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= point.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					p_s1[r][c] <= $signed(rows[r][16*c +: 16]) * w[c];
				end
			end
			cam_s2.xc <= CAM_W'(p_s1[0][0]) + CAM_W'(p_s1[0][1]) + CAM_W'(p_s1[0][2])
				+ (CAM_W'(t[0]) <<< 14);
			cam_s2.yc <= CAM_W'(p_s1[1][0]) + CAM_W'(p_s1[1][1]) + CAM_W'(p_s1[1][2])
				+ (CAM_W'(t[1]) <<< 14);
			cam_s2.zc <= CAM_W'(p_s1[2][0]) + CAM_W'(p_s1[2][1]) + CAM_W'(p_s1[2][2])
				+ (CAM_W'(t[2]) <<< 14);
		end
	end

endmodule

// ===== design/pprd_queue.sv =====
// Short queue between front and back ends, holding camera-frame points.
// Depends on pprd_pkg.
module pprd_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pprd_pkg::cam_t wdata,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output pprd_pkg::cam_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pprd_pkg::cam_t  mem_q [0:DEPTH-1];
	logic [PW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

// ===== design/pprd_back.sv =====
// Back end: pipelined perspective division, radial distortion and intrinsics.
// Depends on pprd_pkg and pprd_if.
module pprd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pprd_pkg::cfg_t cfg,
	input  logic           empty,
	input  pprd_pkg::cam_t head,
	output logic           pop,
	pprd_out_if.source     pixel
);

	localparam int CW = pprd_pkg::CAM_W;

	typedef struct packed {
		logic          zero;
		logic          negx;
		logic          negy;
		logic          satx;
		logic          saty;
		logic [CW-1:0] d;
		logic [30:0]   nxlo;
		logic [30:0]   nylo;
		logic [CW-1:0] rx;
		logic [CW-1:0] ry;
		logic [30:0]   qx;
		logic [30:0]   qy;
	} div_st_t;

	logic               en;
	logic               dvv [0:31];
	div_st_t            dv [0:31];
	logic [CW-1:0]      xm, ym, zm;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic               z_s1, z_s2, z_s3, z_s4, z_s5, z_s6, z_s7, z_s8, z_s9, z_s10;
	logic               f_s1, f_s2, f_s3, f_s4, f_s5, f_s6, f_s7, f_s8, f_s9, f_s10;
	logic signed [31:0] xn_s1, yn_s1, xn_s2, yn_s2, xn_s3, yn_s3, xn_s4, yn_s4;
	logic signed [31:0] xn_s5, yn_s5, xn_s6, yn_s6, xn_s7, yn_s7;
	logic [63:0]        sqx_s2, sqy_s2;
	logic [30:0]        r2_s3, r2_s4, r2_s5, r4_s5;
	logic [61:0]        r2sq_s4;
	logic signed [47:0] a_s6, b_s6;
	logic signed [31:0] s_s7;
	logic signed [63:0] px_s8, py_s8;
	logic signed [31:0] xd_s9, yd_s9;
	logic signed [63:0] mu1_s10, mu2_s10, mv_s10;
	logic signed [31:0] u_s11, vv_s11;
	logic [1:0]         st_s11;

	logic [63:0]        sq;
	logic [47:0]        r2raw;
	logic [45:0]        r4raw;
	logic signed [49:0] ssum;
	logic signed [64:0] usum;
	pprd_pkg::clamp_t   cs, cxd, cyd, cu, cv;

	assign en  = !v_s11 || pixel.ready;
	assign pop = en && !empty;
	assign pixel.valid   = v_s11;
	assign pixel.image_u = u_s11;
	assign pixel.image_v = vv_s11;
	assign pixel.status  = st_s11;

	assign xm = head.xc[CW-1] ? CW'(-head.xc) : CW'(head.xc);
	assign ym = head.yc[CW-1] ? CW'(-head.yc) : CW'(head.yc);
	assign zm = head.zc[CW-1] ? CW'(-head.zc) : CW'(head.zc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv[0] <= 1'b0;
		end else if (en) begin
			dvv[0] <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv[0].zero <= (head.zc == '0);
			dv[0].negx <= head.xc[CW-1] ^ head.zc[CW-1];
			dv[0].negy <= head.yc[CW-1] ^ head.zc[CW-1];
			dv[0].satx <= 1'b0;
			dv[0].saty <= 1'b0;
			dv[0].d    <= zm;
			dv[0].nxlo <= {xm[14:0], 16'b0};
			dv[0].nylo <= {ym[14:0], 16'b0};
			dv[0].rx   <= xm >> 15;
			dv[0].ry   <= ym >> 15;
			dv[0].qx   <= '0;
			dv[0].qy   <= '0;
		end
	end

	for (genvar k = 0; k < 31; k++) begin : g_div
		localparam int B = 30 - k;
		logic [CW:0] tx, ty;
		logic        gx, gy;
		div_st_t     nx;

		assign tx = {dv[k].rx, dv[k].nxlo[B]};
		assign ty = {dv[k].ry, dv[k].nylo[B]};
		assign gx = (tx >= {1'b0, dv[k].d});
		assign gy = (ty >= {1'b0, dv[k].d});

		always_comb begin
			nx = dv[k];
			if (k == 0) begin
				nx.satx = (dv[k].rx >= dv[k].d);
				nx.saty = (dv[k].ry >= dv[k].d);
			end
			nx.rx = gx ? CW'(tx - {1'b0, dv[k].d}) : CW'(tx);
			nx.ry = gy ? CW'(ty - {1'b0, dv[k].d}) : CW'(ty);
			nx.qx[B] = gx;
			nx.qy[B] = gy;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv[k+1] <= 1'b0;
			end else if (en) begin
				dvv[k+1] <= dvv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) dv[k+1] <= nx;
		end
	end

	always_comb begin
		sq    = sqx_s2 + sqy_s2;
		r2raw = sq[63:16];
		r4raw = r2sq_s4[61:16];
		ssum  = 50'(a_s6) + 50'(b_s6) + 50'sd268435456;
		cs    = pprd_pkg::clamp32(64'(ssum >>> 12), 1'b1);
		cxd   = pprd_pkg::clamp32(64'($signed(px_s8[63:16])), 1'b1);
		cyd   = pprd_pkg::clamp32(64'($signed(py_s8[63:16])), 1'b1);
		usum  = 65'(mu1_s10) + 65'(mu2_s10);
		cu    = pprd_pkg::clamp32(64'($signed(cfg.pp[31:0])) + 64'($signed(usum[64:16])),
			1'b0);
		cv    = pprd_pkg::clamp32(64'($signed(cfg.pp[63:32])) + 64'($signed(mv_s10[63:16])),
			1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11}     <= '0;
		end else if (en) begin
			v_s1  <= dvv[31];
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xn_s1 <= dv[31].negx ? -$signed({1'b0, dv[31].satx ? 31'h7FFFFFFF : dv[31].qx})
				: $signed({1'b0, dv[31].satx ? 31'h7FFFFFFF : dv[31].qx});
			yn_s1 <= dv[31].negy ? -$signed({1'b0, dv[31].saty ? 31'h7FFFFFFF : dv[31].qy})
				: $signed({1'b0, dv[31].saty ? 31'h7FFFFFFF : dv[31].qy});
			z_s1  <= dv[31].zero;
			f_s1  <= dv[31].satx || dv[31].saty;

			sqx_s2 <= 64'(xn_s1) * 64'(xn_s1);
			sqy_s2 <= 64'(yn_s1) * 64'(yn_s1);
			{xn_s2, yn_s2, z_s2, f_s2} <= {xn_s1, yn_s1, z_s1, f_s1};

			r2_s3 <= (r2raw > 48'h7FFFFFFF) ? 31'h7FFFFFFF : r2raw[30:0];
			f_s3  <= f_s2 || (r2raw > 48'h7FFFFFFF);
			{xn_s3, yn_s3, z_s3} <= {xn_s2, yn_s2, z_s2};

			r2sq_s4 <= r2_s3 * r2_s3;
			{r2_s4, xn_s4, yn_s4, z_s4, f_s4} <= {r2_s3, xn_s3, yn_s3, z_s3, f_s3};

			r4_s5 <= (r4raw > 46'h7FFFFFFF) ? 31'h7FFFFFFF : r4raw[30:0];
			f_s5  <= f_s4 || (r4raw > 46'h7FFFFFFF);
			{r2_s5, xn_s5, yn_s5, z_s5} <= {r2_s4, xn_s4, yn_s4, z_s4};

			a_s6 <= $signed(cfg.skd[47:32]) * $signed({1'b0, r2_s5});
			b_s6 <= $signed(cfg.skd[63:48]) * $signed({1'b0, r4_s5});
			{xn_s6, yn_s6, z_s6, f_s6} <= {xn_s5, yn_s5, z_s5, f_s5};

			s_s7 <= cs.val;
			f_s7 <= f_s6 || cs.sat;
			{xn_s7, yn_s7, z_s7} <= {xn_s6, yn_s6, z_s6};

			px_s8 <= xn_s7 * s_s7;
			py_s8 <= yn_s7 * s_s7;
			{z_s8, f_s8} <= {z_s7, f_s7};

			xd_s9 <= cxd.val;
			yd_s9 <= cyd.val;
			f_s9  <= f_s8 || cxd.sat || cyd.sat;
			z_s9  <= z_s8;

			mu1_s10 <= $signed(cfg.focal[31:0]) * xd_s9;
			mu2_s10 <= $signed(cfg.skd[31:0]) * yd_s9;
			mv_s10  <= $signed(cfg.focal[63:32]) * yd_s9;
			{z_s10, f_s10} <= {z_s9, f_s9};

			if (z_s10) begin
				u_s11  <= '0;
				vv_s11 <= '0;
				st_s11 <= pprd_pkg::ST_DEPTH_ZERO;
			end else begin
				u_s11  <= cu.val;
				vv_s11 <= cv.val;
				st_s11 <= (f_s10 || cu.sat || cv.sat) ? pprd_pkg::ST_SATURATED : pprd_pkg::ST_OK;
			end
		end
	end

endmodule

// ===== design/pinhole_project_radial_distortion.sv =====
// Top level of the pinhole projection block with two-term radial distortion.
// Depends on pprd_pkg, pprd_if, pprd_front, pprd_queue and pprd_back.
//
// One world point is accepted per clock cycle unless a full queue stalls the front
// end, and one pixel transaction leaves per point, in order. A point passes through
// two stages of camera-frame transform, the queue, 32 stages of the quotient pipeline
// (a setup stage, then one quotient bit per stage) and 11 stages of distortion
// and intrinsics. The quotient pipeline sets the latency; throughput stays one point
// per cycle while the pixel side keeps taking transactions. Configuration writes are
// always taken and must only be issued while the block is empty.
module pinhole_project_radial_distortion #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	pprd_cfg_if.sink   cfg,
	pprd_in_if.sink    point,
	pprd_out_if.source pixel
);

	pprd_pkg::cfg_t cfg_q;
	pprd_pkg::cam_t f_item, q_head;
	logic           push, pop, full, empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot0  <= 48'h0000_0000_4000;
			cfg_q.rot1  <= 48'h0000_4000_0000;
			cfg_q.rot2  <= 48'h4000_0000_0000;
			cfg_q.txy   <= '0;
			cfg_q.tz    <= '0;
			cfg_q.focal <= 64'h0001_0000_0001_0000;
			cfg_q.pp    <= '0;
			cfg_q.skd   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				pprd_pkg::CFG_ROT0:  cfg_q.rot0  <= cfg.data[47:0];
				pprd_pkg::CFG_ROT1:  cfg_q.rot1  <= cfg.data[47:0];
				pprd_pkg::CFG_ROT2:  cfg_q.rot2  <= cfg.data[47:0];
				pprd_pkg::CFG_TXY:   cfg_q.txy   <= cfg.data;
				pprd_pkg::CFG_TZ:    cfg_q.tz    <= cfg.data[31:0];
				pprd_pkg::CFG_FOCAL: cfg_q.focal <= cfg.data;
				pprd_pkg::CFG_PP:    cfg_q.pp    <= cfg.data;
				pprd_pkg::CFG_SKD:   cfg_q.skd   <= cfg.data;
				default: ;
			endcase
		end
	end

	pprd_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .point(point),
		.full(full), .push(push), .item(f_item)
	);

	pprd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(f_item), .pop(pop),
		.full(full), .empty(empty), .rdata(q_head)
	);

	pprd_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .empty(empty), .head(q_head),
		.pop(pop), .pixel(pixel)
	);

	a_depth_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.status == pprd_pkg::ST_DEPTH_ZERO
		|-> pixel.image_u == 0 && pixel.image_v == 0)
		else $error("depth-zero result with non-zero coordinates");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid |-> pixel.status != 2'd3)
		else $error("undefined status code");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule
